### hdl/fvsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvsm_pkg
// Shared constants, codes and controller/datapath interface types of the
// four-voice sample mixer.
// ----------------------------------------------------------------------------
package fvsm_pkg;

  // Build constants
  localparam int VOICES           = 4;
  localparam int SAMPLE_ADDR_BITS = 17;
  localparam int VIDX_W           = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MEM_DEPTH        = 1 << SAMPLE_ADDR_BITS;
  localparam int ACC_W            = 16 + $clog2(VOICES) + 1;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int VOICE_W  = 2;
  localparam int ADDR_W   = 17;
  localparam int BYTE_W   = 8;
  localparam int PERIOD_W = 12;
  localparam int VOL_W    = 7;
  localparam int STEP_W   = 16;
  localparam int PHASE_W  = 16;
  localparam int POS_W    = 18;
  localparam int MIX_W    = 16;

  // Pitch math
  localparam logic [31:0]         CLOCK_RATE  = 32'd7093789;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD  = 12'd108;
  localparam logic [VOL_W-1:0]    FULL_VOLUME = 7'd64;

  // rate * 2^16 / 48000 = rate * 512 / 375; the reciprocal below gives the
  // exact floor for every 16-bit rate: floor(rate * STEP_RECIP / 2^STEP_SHIFT)
  localparam logic [25:0] STEP_RECIP  = 26'd45812985;
  localparam int          STEP_SHIFT  = 25;
  localparam int          STEP_PROD_W = 42;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SETUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd2;

  typedef struct packed {
    logic capture;         // latch the item being transferred
    logic mem_we;          // write sample byte
    logic setup_write;     // store voice set-up fields
    logic div_start_rate;  // clock / (2 * period)
    logic step_write;      // store scaled divider result as step
    logic frame_clear;     // clear accumulator and voice counter
    logic advance;         // phase += step, carry into position
    logic locate;          // wrap/end check, issue sample read
    logic emit;            // load mix output register
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              voice_ok;
    logic              period_zero;
    logic              div_busy;
    logic              last_voice;
    logic              out_free;
  } status_t;

endpackage : fvsm_pkg
`default_nettype wire

### hdl/fvsm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvsm_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module fvsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : fvsm_ram
`default_nettype wire

### hdl/fvsm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvsm_datapath
// Item capture, voice state, step divider, sample memory, multiply-accumulate
// and the mix output register.
// ----------------------------------------------------------------------------
module fvsm_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fvsm_pkg::cmd_t                      cmd,
  output      fvsm_pkg::status_t                   status,
  input  wire logic [fvsm_pkg::KIND_W-1:0]         kind,
  input  wire logic [fvsm_pkg::VOICE_W-1:0]        voice,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         address,
  input  wire logic signed [fvsm_pkg::BYTE_W-1:0]  sample_byte,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         sample_length,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         loop_offset,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         loop_length,
  input  wire logic [fvsm_pkg::PERIOD_W-1:0]       period,
  input  wire logic [fvsm_pkg::VOL_W-1:0]          volume,
  input  wire logic                                restart,
  output      logic                                mix_valid,
  input  wire logic                                mix_ready,
  output      logic signed [fvsm_pkg::MIX_W-1:0]   mix
);

  localparam int VW = fvsm_pkg::VIDX_W;
  localparam int AW = fvsm_pkg::ADDR_W;
  localparam int PW = fvsm_pkg::POS_W;
  localparam int CW = fvsm_pkg::ACC_W;
  localparam int MAW = $clog2(fvsm_pkg::MEM_DEPTH);

  localparam logic signed [CW-1:0] MIX_MAX = CW'(32767);
  localparam logic signed [CW-1:0] MIX_MIN = -CW'(32768);

  // Captured item
  logic [fvsm_pkg::KIND_W-1:0]        kind_q;
  logic [fvsm_pkg::VOICE_W-1:0]       voice_q;
  logic [AW-1:0]                      addr_q;
  logic signed [fvsm_pkg::BYTE_W-1:0] byte_q;
  logic [AW-1:0]                      len_q;
  logic [AW-1:0]                      loff_q;
  logic [AW-1:0]                      llen_q;
  logic [fvsm_pkg::PERIOD_W-1:0]      period_q;
  logic [fvsm_pkg::VOL_W-1:0]         vol_q;
  logic                               restart_q;

  // Voice state
  logic [AW-1:0]                      v_base     [fvsm_pkg::VOICES];
  logic [AW-1:0]                      v_len      [fvsm_pkg::VOICES];
  logic [AW-1:0]                      v_lstart   [fvsm_pkg::VOICES];
  logic [PW-1:0]                      v_lend     [fvsm_pkg::VOICES];
  logic                               v_looped   [fvsm_pkg::VOICES];
  logic [fvsm_pkg::STEP_W-1:0]        v_step     [fvsm_pkg::VOICES];
  logic [fvsm_pkg::PHASE_W-1:0]       v_phase    [fvsm_pkg::VOICES];
  logic [PW-1:0]                      v_pos      [fvsm_pkg::VOICES];
  logic [fvsm_pkg::VOL_W-1:0]         v_gain     [fvsm_pkg::VOICES];

  logic [VW-1:0] vidx;
  logic [VW-1:0] sidx;
  logic [PW-1:0] pos_tmp;

  // Divider
  logic [16:0] div_rem;
  logic [31:0] div_q;
  logic [15:0] div_d;
  logic [4:0]  div_cnt;
  logic        div_busy;

  // MAC
  logic                         mac_pend;
  logic                         mac_silent;
  logic [fvsm_pkg::VOL_W-1:0]   mac_gain;
  logic signed [CW-1:0]         acc;

  // Memory
  logic                               mem_we;
  logic [MAW-1:0]                     mem_addr;
  logic [fvsm_pkg::BYTE_W-1:0]        mem_rdata;

  // Combinational
  logic [fvsm_pkg::PERIOD_W-1:0] pclamp;
  logic [15:0]                   rate_div;
  logic [16:0]                   trial;
  logic                          trial_ge;
  logic [fvsm_pkg::STEP_PROD_W-1:0] step_prod;
  logic [16:0]                   ph_sum;
  logic [PW-1:0]                 pos_adv;
  logic                          wrap;
  logic                          silent;
  logic [PW-1:0]                 pos_fin;
  logic [18:0]                   addr_sum;
  logic [fvsm_pkg::VOL_W-1:0]    vol_clamp;
  logic                          looped_new;
  logic signed [15:0]            prod;
  logic signed [CW-1:0]          mix_sat;

  assign sidx = VW'(voice_q);

  assign pclamp   = (period_q < fvsm_pkg::MIN_PERIOD) ? fvsm_pkg::MIN_PERIOD : period_q;
  assign rate_div = {3'b000, pclamp, 1'b0};
  assign trial    = {div_rem[15:0], div_q[31]};
  assign trial_ge = trial >= {1'b0, div_d};

  // rate to 0.16 step at the output rate (rate < 2^16 after the division)
  assign step_prod = fvsm_pkg::STEP_PROD_W'(div_q[15:0]) *
                     fvsm_pkg::STEP_PROD_W'(fvsm_pkg::STEP_RECIP);

  assign ph_sum  = {1'b0, v_phase[vidx]} + {1'b0, v_step[vidx]};
  assign pos_adv = v_pos[vidx] + {{(PW-1){1'b0}}, ph_sum[16]};

  assign wrap     = v_looped[vidx] && (pos_tmp >= v_lend[vidx]);
  assign silent   = !v_looped[vidx] && (pos_tmp >= {1'b0, v_len[vidx]});
  assign pos_fin  = wrap ? {1'b0, v_lstart[vidx]} : pos_tmp;
  assign addr_sum = 19'(v_base[vidx]) + 19'(pos_fin);

  assign vol_clamp  = (vol_q > fvsm_pkg::FULL_VOLUME) ? fvsm_pkg::FULL_VOLUME : vol_q;
  assign looped_new = (loff_q > AW'(2)) || (llen_q > AW'(2));

  assign prod = $signed(mem_rdata) * $signed({1'b0, mac_gain});

  assign mix_sat = (acc > MIX_MAX) ? MIX_MAX : ((acc < MIX_MIN) ? MIX_MIN : acc);

  assign mem_we   = cmd.mem_we;
  assign mem_addr = cmd.mem_we ? MAW'(addr_q) : MAW'(addr_sum);

  always_comb begin
    status.kind        = kind_q;
    status.voice_ok    = int'(voice_q) < fvsm_pkg::VOICES;
    status.period_zero = period_q == '0;
    status.div_busy    = div_busy;
    status.last_voice  = vidx == VW'(fvsm_pkg::VOICES - 1);
    status.out_free    = !mix_valid || mix_ready;
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q    <= kind;
      voice_q   <= voice;
      addr_q    <= address;
      byte_q    <= sample_byte;
      len_q     <= sample_length;
      loff_q    <= loop_offset;
      llen_q    <= loop_length;
      period_q  <= period;
      vol_q     <= volume;
      restart_q <= restart;
    end
  end

  // Voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fvsm_pkg::VOICES; i++) begin
        v_base[i]   <= '0;
        v_len[i]    <= '0;
        v_lstart[i] <= '0;
        v_lend[i]   <= '0;
        v_looped[i] <= 1'b0;
        v_step[i]   <= '0;
        v_phase[i]  <= '0;
        v_pos[i]    <= '0;
        v_gain[i]   <= fvsm_pkg::FULL_VOLUME;
      end
      vidx <= '0;
    end else begin
      if (cmd.setup_write) begin
        v_base[sidx]   <= addr_q;
        v_len[sidx]    <= len_q;
        v_lstart[sidx] <= loff_q;
        v_lend[sidx]   <= PW'(loff_q) + PW'(llen_q);
        v_looped[sidx] <= looped_new;
        v_gain[sidx]   <= vol_clamp;
        if (restart_q) begin
          v_pos[sidx]   <= '0;
          v_phase[sidx] <= '0;
        end
      end
      if (cmd.step_write) begin
        v_step[sidx] <= step_prod[fvsm_pkg::STEP_SHIFT +: fvsm_pkg::STEP_W];
      end
      if (cmd.frame_clear) begin
        vidx <= '0;
      end
      if (cmd.advance) begin
        v_phase[vidx] <= ph_sum[15:0];
      end
      if (cmd.locate) begin
        v_pos[vidx] <= pos_fin;
        if (silent) begin
          v_step[vidx] <= '0;
        end
        vidx <= vidx + VW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      pos_tmp <= pos_adv;
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start_rate) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 5'd31) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_rate) begin
      div_q   <= fvsm_pkg::CLOCK_RATE;
      div_d   <= rate_div;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (div_busy) begin
      div_rem <= trial_ge ? (trial - {1'b0, div_d}) : trial;
      div_q   <= {div_q[30:0], trial_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // Multiply-accumulate, in the cycle after the sample read
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_pend <= 1'b0;
    end else begin
      mac_pend <= cmd.locate;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.locate) begin
      mac_silent <= silent;
      mac_gain   <= v_gain[vidx];
    end
    if (cmd.frame_clear) begin
      acc <= '0;
    end else if (mac_pend && !mac_silent) begin
      acc <= acc + CW'(prod);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (cmd.emit) begin
      mix_valid <= 1'b1;
    end else if (mix_ready) begin
      mix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mix <= mix_sat[fvsm_pkg::MIX_W-1:0];
    end
  end

  fvsm_ram #(
    .WIDTH (fvsm_pkg::BYTE_W),
    .DEPTH (fvsm_pkg::MEM_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (byte_q),
    .rdata (mem_rdata)
  );

endmodule : fvsm_datapath
`default_nettype wire

### hdl/fvsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fvsm_ctrl
// Sequencer for the mixer: decodes each item and steps the datapath through
// load, voice set-up with step division, and the per-voice frame walk.
// ----------------------------------------------------------------------------
module fvsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output      logic              item_ready,
  input  wire fvsm_pkg::status_t status,
  output      fvsm_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SETUP,
    ST_DIV_RATE,
    ST_ADVANCE,
    ST_LOCATE,
    ST_MAC_WAIT,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.capture = item_valid;
        if (item_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.kind)
          fvsm_pkg::KIND_LOAD: begin
            cmd.mem_we = 1'b1;
            state_next = ST_IDLE;
          end
          fvsm_pkg::KIND_SETUP: begin
            state_next = status.voice_ok ? ST_SETUP : ST_IDLE;
          end
          fvsm_pkg::KIND_FRAME: begin
            cmd.frame_clear = 1'b1;
            state_next      = ST_ADVANCE;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SETUP: begin
        cmd.setup_write = 1'b1;
        if (status.period_zero) begin
          state_next = ST_IDLE;
        end else begin
          cmd.div_start_rate = 1'b1;
          state_next         = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        if (!status.div_busy) begin
          cmd.step_write = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next  = ST_LOCATE;
      end
      ST_LOCATE: begin
        cmd.locate = 1'b1;
        state_next = status.last_voice ? ST_MAC_WAIT : ST_ADVANCE;
      end
      ST_MAC_WAIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : fvsm_ctrl
`default_nettype wire

### hdl/four_voice_sample_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_voice_sample_mixer
// Four-voice wavetable sample playback mixer: sample load, voice set-up and
// frame mixing over a shared byte-wide sample memory.
// ----------------------------------------------------------------------------
// The block takes one item at a time and accepts the next as soon as the
// current one is done, even while a mix result still waits in the output
// register. A sample load writes the byte in the decode state. A voice
// set-up with period 0 ends after the set-up state; otherwise the rate comes
// from one 32-step restoring division (clock over twice the clamped period)
// run one bit per cycle, and is scaled to a step at the output rate by a
// multiply with a fixed reciprocal as the step is stored. A frame walk is
// paced by the single sample memory port: each voice needs one read, and
// each voice is walked in two steps (phase advance, then loop/end check with
// the read). The product of byte and volume is accumulated in the cycle
// after the read. A frame whose mix register is still occupied waits at
// the end until the previous result is taken. Nothing is accepted while
// reset is high.
// Sample memory has no reset; reading a never-loaded byte returns anything.
// ----------------------------------------------------------------------------
module four_voice_sample_mixer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // item channel
  input  wire logic                                item_valid,
  output      logic                                item_ready,
  input  wire logic [fvsm_pkg::KIND_W-1:0]         kind,
  input  wire logic [fvsm_pkg::VOICE_W-1:0]        voice,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         address,
  input  wire logic signed [fvsm_pkg::BYTE_W-1:0]  sample_byte,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         sample_length,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         loop_offset,
  input  wire logic [fvsm_pkg::ADDR_W-1:0]         loop_length,
  input  wire logic [fvsm_pkg::PERIOD_W-1:0]       period,
  input  wire logic [fvsm_pkg::VOL_W-1:0]          volume,
  input  wire logic                                restart,
  // result channel
  output      logic                                mix_valid,
  input  wire logic                                mix_ready,
  output      logic signed [fvsm_pkg::MIX_W-1:0]   mix
);

  // Command and status between sequencer and datapath
  fvsm_pkg::cmd_t    cmd;
  fvsm_pkg::status_t status;

  // Sequencer: owns item_ready, decodes the captured kind
  fvsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: voice registers, divider, sample RAM, MAC, mix register
  fvsm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .voice         (voice),
    .address       (address),
    .sample_byte   (sample_byte),
    .sample_length (sample_length),
    .loop_offset   (loop_offset),
    .loop_length   (loop_length),
    .period        (period),
    .volume        (volume),
    .restart       (restart),
    .mix_valid     (mix_valid),
    .mix_ready     (mix_ready),
    .mix           (mix)
  );

endmodule : four_voice_sample_mixer
`default_nettype wire
